// ===== rtl/ggp_pkg.sv =====
package ggp_pkg;

    localparam int BUF_DEPTH   = 65536;
    localparam int ADDR_W      = $clog2(BUF_DEPTH);
    localparam int NUM_GRAINS  = 3;
    localparam int WIN_ENTRIES = 1024;
    localparam int WIN_W       = $clog2(WIN_ENTRIES);
    localparam int FRAC_W      = 16;
    localparam int SMP_W       = 16;
    localparam int MIX_W       = 18;
    localparam int LEN_W       = 17;
    localparam int DUR_W       = 17;
    localparam int OFF_W       = 16;
    localparam int SPD_W       = 21;
    localparam int CFG_W       = 21;
    localparam int CFG_IDX_W   = 3;
    localparam int POS_W       = DUR_W + FRAC_W;
    localparam int RATE_W      = SPD_W + 2;
    localparam int DIV_W       = DUR_W + WIN_W;
    localparam int DVS_W       = 17;
    localparam int GRAIN_W     = 2;

    localparam logic [DUR_W-1:0] MIN_DUR   = DUR_W'(48);
    localparam logic [LEN_W-1:0] LEN_RST   = LEN_W'(65536);
    localparam logic [DUR_W-1:0] DUR_RST   = DUR_W'(65536);
    localparam logic [SPD_W-1:0] SPD_RST   = SPD_W'(65536);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(BUF_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_DIV0, ST_DIV1, ST_DIV2, ST_RD0, ST_RD1,
        ST_RD2, ST_MUL0, ST_MUL1, ST_UPD, ST_DONE
    } t_state;

    typedef logic [WIN_ENTRIES-1:0][SMP_W-1:0] t_win_tab;

    // Half-sine in Q30 by truncated odd Taylor series, rounded to Q15.
    function automatic logic [SMP_W-1:0] half_sine(int unsigned i);
        longint unsigned pi_q30;
        longint unsigned one_q30;
        longint unsigned m;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        pi_q30  = 64'd3373259426;
        one_q30 = 64'd1 << 30;
        m  = (i > WIN_ENTRIES - i) ? longint'(WIN_ENTRIES - i) : longint'(i);
        x  = (pi_q30 * m) >> WIN_W;
        x2 = (x * x) >> 30;
        // Horner steps, innermost term first.
        t  = one_q30 - ((x2 * one_q30) >> 30) / 64'd110;
        t  = one_q30 - ((x2 * t) >> 30) / 64'd72;
        t  = one_q30 - ((x2 * t) >> 30) / 64'd42;
        t  = one_q30 - ((x2 * t) >> 30) / 64'd20;
        t  = one_q30 - ((x2 * t) >> 30) / 64'd6;
        s = (x * t) >> 30;
        s = (s + (64'd1 << 14)) >> 15;
        if (s > 64'd32767)
            s = 64'd32767;
        return s[SMP_W-1:0];
    endfunction

    function automatic t_win_tab build_win();
        t_win_tab tab;
        for (int i = 0; i < WIN_ENTRIES; i++)
            tab[i] = half_sine(i);
        return tab;
    endfunction

    localparam t_win_tab WIN_TAB = build_win();

endpackage

// ===== rtl/ggp_ram.sv =====
module ggp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/ggp_div.sv =====
module ggp_div
    import ggp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_div;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // One restoring step per cycle, quotient shifts in behind the dividend.
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/granular_grain_player.sv =====
// Granular player: three grains read from a 64K-sample memory and are mixed.
// Input channel (i_valid/o_ready): mode 0 stores write_sample at
// write_address when taken and yields no result. Mode 1 is a tick:
// it yields one mixed_sample on the output channel (o_valid/i_ready).
// A tick runs each grain through one shared restoring divider (27 steps per
// division, three divisions per grain: two index wraps and the window index),
// then the sample memory, then one shared 17x17 multiplier used twice.
// o_ready is low from acceptance of a tick until its result is loaded into the
// output register, so no new item is taken while a tick runs. Writes are
// taken one per cycle while idle.
// The finished result sits in an output register; the next item is taken
// while it waits. If the receiver still stalls when the following tick
// finishes, the block holds until the register frees.
// Configuration: i_cfg_we writes register i_cfg_idx (0 buffer length,
// 1 grain duration, 2 read offset, 3 speed); write only while
// idle. Writing the duration restarts all grains at position zero.
// Reset (synchronous, active low) restores the register defaults and grain
// positions; sample memory contents stay undefined until written.
module granular_grain_player
    import ggp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_mode,
    input  logic [ADDR_W-1:0]    i_write_address,
    input  logic signed [SMP_W-1:0] i_write_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [MIX_W-1:0] o_mixed_sample,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [LEN_W-1:0]   r_len;
    logic [DUR_W-1:0]   r_dur;
    logic [OFF_W-1:0]   r_off;
    logic [SPD_W-1:0]   r_spd;
    logic [POS_W-1:0]   r_pos [NUM_GRAINS];
    logic [GRAIN_W-1:0] r_g;
    logic [ADDR_W-1:0]  r_i0;
    logic [ADDR_W-1:0]  r_i1;
    logic [WIN_W-1:0]   r_widx;
    logic signed [SMP_W-1:0] r_s0;
    logic signed [SMP_W-1:0] r_s1;
    logic [SMP_W-1:0]   r_w;
    logic signed [SMP_W:0]   r_v;
    logic [POS_W:0]     r_q;
    logic signed [MIX_W-1:0] r_acc;
    logic signed [MIX_W-1:0] r_out;
    logic               r_out_valid;

    logic               w_accept;
    logic [LEN_W-1:0]   w_len;
    logic [DUR_W-1:0]   w_dur;
    logic [POS_W-1:0]   w_p;
    logic [DUR_W-1:0]   w_n;
    logic [FRAC_W-1:0]  w_f;
    logic [DUR_W:0]     w_n1;
    logic [POS_W-1:0]   w_span;
    logic [POS_W:0]     w_span2;
    logic [RATE_W-1:0]  w_rate;
    logic               w_div_start;
    logic [DIV_W-1:0]   w_dividend;
    logic [DVS_W-1:0]   w_divisor;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_quot;
    logic [DVS_W-1:0]   w_rem;
    logic [ADDR_W-1:0]  w_raddr;
    logic [SMP_W-1:0]   w_rdata;
    logic signed [SMP_W:0]     w_ma;
    logic signed [SMP_W:0]     w_mb;
    logic signed [2*SMP_W+1:0] w_prod;
    logic               w_load_out;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        if (r_len == '0)
            w_len = LEN_W'(1);
        else if (r_len > LEN_MAX)
            w_len = LEN_MAX;
        else
            w_len = r_len;
        w_dur   = (r_dur < MIN_DUR) ? MIN_DUR : r_dur;
        w_span  = {w_dur, {FRAC_W{1'b0}}};
        w_span2 = {w_dur, {(FRAC_W+1){1'b0}}};
        w_p    = r_pos[r_g];
        w_n    = w_p[POS_W-1:FRAC_W];
        w_f    = w_p[FRAC_W-1:0];
        // Second tap wraps within the grain.
        w_n1   = ({1'b0, w_n} + 1'b1 == {1'b0, w_dur}) ? '0 : {1'b0, w_n} + 1'b1;
        case (r_g)
            2'd0:    w_rate = RATE_W'(r_spd);
            2'd1:    w_rate = RATE_W'(r_spd) + RATE_W'(r_spd >> 1);
            default: w_rate = {1'b0, r_spd, 1'b0};
        endcase
    end

    // Divider operand select: read index, neighbor index, window index.
    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = '0;
        w_divisor   = w_len;
        case (r_state)
            ST_LOAD: begin
                w_div_start = 1'b1;
                w_dividend  = DIV_W'(w_n) + DIV_W'(r_off);
            end
            ST_DIV0: begin
                w_div_start = w_div_done;
                w_dividend  = DIV_W'(w_n1) + DIV_W'(r_off);
            end
            ST_DIV1: begin
                w_div_start = w_div_done;
                w_dividend  = {w_n, {WIN_W{1'b0}}};
                w_divisor   = w_dur;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    ggp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_raddr = (r_state == ST_RD0) ? r_i0 : r_i1;

    ggp_ram #(
        .WIDTH (SMP_W),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && !i_mode),
        .i_waddr (i_write_address),
        .i_wdata (i_write_sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Shared multiplier: interpolation step, then window weight.
    always_comb begin
        if (r_state == ST_MUL0) begin
            w_ma = (SMP_W+1)'(r_s1) - (SMP_W+1)'(r_s0);
            w_mb = {1'b0, w_f};
        end else begin
            w_ma = r_v;
            w_mb = {1'b0, r_w};
        end
        w_prod = w_ma * w_mb;
    end

    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept && i_mode) n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DIV0;
            ST_DIV0: if (w_div_done) n_state = ST_DIV1;
            ST_DIV1: if (w_div_done) n_state = ST_DIV2;
            ST_DIV2: if (w_div_done) n_state = ST_RD0;
            ST_RD0:  n_state = ST_RD1;
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_MUL0;
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_UPD;
            ST_UPD:  n_state = (r_g == GRAIN_W'(NUM_GRAINS - 1)) ? ST_DONE : ST_LOAD;
            ST_DONE: if (w_load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RST;
            r_dur <= DUR_RST;
            r_off <= '0;
            r_spd <= SPD_RST;
            r_g   <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_GRAINS; k++)
                r_pos[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LENGTH: r_len <= i_cfg_data[LEN_W-1:0];
                    REG_DURATION: begin
                        r_dur <= i_cfg_data[DUR_W-1:0];
                        for (int k = 0; k < NUM_GRAINS; k++)
                            r_pos[k] <= '0;
                    end
                    REG_OFFSET: r_off <= i_cfg_data[OFF_W-1:0];
                    REG_SPEED:  r_spd <= i_cfg_data[SPD_W-1:0];
                    default: ;
                endcase
            end
            if (w_accept && i_mode)
                r_g <= '0;
            if (r_state == ST_UPD) begin
                // Sum stays below three spans: drop one or two spans.
                if (r_q >= w_span2)
                    r_pos[r_g] <= POS_W'(r_q - w_span2);
                else if (r_q >= {1'b0, w_span})
                    r_pos[r_g] <= POS_W'(r_q - {1'b0, w_span});
                else
                    r_pos[r_g] <= r_q[POS_W-1:0];
                r_g <= (r_g == GRAIN_W'(NUM_GRAINS - 1)) ? '0 : r_g + 1'b1;
            end
            if (w_load_out)
                r_out_valid <= 1'b1;
            else if (i_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_mode)
            r_acc <= '0;
        case (r_state)
            ST_DIV0: if (w_div_done) r_i0 <= w_rem[ADDR_W-1:0];
            ST_DIV1: if (w_div_done) r_i1 <= w_rem[ADDR_W-1:0];
            ST_DIV2: if (w_div_done) r_widx <= w_quot[WIN_W-1:0];
            ST_RD1:  r_s0 <= w_rdata;
            ST_RD2: begin
                r_s1 <= w_rdata;
                r_w  <= WIN_TAB[r_widx];
            end
            ST_MUL0: r_v <= (SMP_W+1)'(r_s0) + (SMP_W+1)'(w_prod >>> FRAC_W);
            ST_MUL1: begin
                r_acc <= r_acc + MIX_W'(w_prod >>> (SMP_W - 1));
                r_q   <= {1'b0, w_p} + (POS_W+1)'(w_rate);
            end
            default: ;
        endcase
        if (w_load_out)
            r_out <= r_acc;
    end

    assign o_valid        = r_out_valid;
    assign o_mixed_sample = r_out;

endmodule
